@@ design/cc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package cc_pkg;

    localparam int SQ_N = 31;
    localparam int DV_N = 16;
    localparam int Q_DEPTH = 4;

    typedef enum logic [1:0] {
        KIND_MISS,
        KIND_HIT,
        KIND_COINCIDENT
    } kind_t;

    typedef struct packed {
        kind_t              kind;
        logic [61:0]        d2;
        logic signed [31:0] ax;
        logic signed [31:0] ay;
        logic [29:0]        ar;
        logic [30:0]        adx;
        logic [30:0]        ady;
        logic [30:0]        rsum;
        logic               sx;
        logic               sy;
    } job_t;

endpackage

`default_nettype wire

@@ design/cc_front.sv @@
`timescale 1ns / 1ps
`default_nettype none

module cc_front import cc_pkg::*; (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic signed [31:0] s_a_center_x,
    input  wire logic signed [31:0] s_a_center_y,
    input  wire logic [29:0]        s_a_radius,
    input  wire logic signed [31:0] s_b_center_x,
    input  wire logic signed [31:0] s_b_center_y,
    input  wire logic [29:0]        s_b_radius,
    output logic                    job_valid,
    output job_t                    job,
    input  wire logic               job_ready
);

    logic en;

    logic signed [32:0] dx, dy;
    logic [32:0] adx_w, ady_w;
    logic [30:0] rsum_w;

    logic               f1_v_reg;
    logic signed [31:0] f1_ax_reg, f1_ay_reg;
    logic [29:0]        f1_ar_reg;
    logic [30:0]        f1_adx_reg, f1_ady_reg, f1_rsum_reg;
    logic               f1_sx_reg, f1_sy_reg, f1_rej_reg;

    logic               f2_v_reg;
    logic signed [31:0] f2_ax_reg, f2_ay_reg;
    logic [29:0]        f2_ar_reg;
    logic [30:0]        f2_adx_reg, f2_ady_reg, f2_rsum_reg;
    logic               f2_sx_reg, f2_sy_reg, f2_rej_reg;
    logic [61:0]        f2_sqx_reg, f2_sqy_reg, f2_rs2_reg;

    logic [62:0] d2_w;
    job_t        job_next;
    logic        f3_v_reg;
    job_t        f3_job_reg;

    assign en = !f3_v_reg || job_ready;
    assign s_ready = en;

    always_comb begin
        dx = {s_b_center_x[31], s_b_center_x} - {s_a_center_x[31], s_a_center_x};
        dy = {s_b_center_y[31], s_b_center_y} - {s_a_center_y[31], s_a_center_y};
        adx_w = dx[32] ? 33'(-dx) : 33'(dx);
        ady_w = dy[32] ? 33'(-dy) : 33'(dy);
        rsum_w = {1'b0, s_a_radius} + {1'b0, s_b_radius};
    end

    always_comb begin
        d2_w = {1'b0, f2_sqx_reg} + {1'b0, f2_sqy_reg};
        job_next.d2 = d2_w[61:0];
        job_next.ax = f2_ax_reg;
        job_next.ay = f2_ay_reg;
        job_next.ar = f2_ar_reg;
        job_next.adx = f2_adx_reg;
        job_next.ady = f2_ady_reg;
        job_next.rsum = f2_rsum_reg;
        job_next.sx = f2_sx_reg;
        job_next.sy = f2_sy_reg;
        if (f2_rej_reg || (d2_w > {1'b0, f2_rs2_reg})) begin
            job_next.kind = KIND_MISS;
        end else if (d2_w == 63'd0) begin
            job_next.kind = KIND_COINCIDENT;
        end else begin
            job_next.kind = KIND_HIT;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f1_v_reg <= 1'b0;
            f2_v_reg <= 1'b0;
            f3_v_reg <= 1'b0;
        end else if (en) begin
            f1_v_reg <= s_valid;
            f2_v_reg <= f1_v_reg;
            f3_v_reg <= f2_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            f1_ax_reg <= s_a_center_x;
            f1_ay_reg <= s_a_center_y;
            f1_ar_reg <= s_a_radius;
            f1_adx_reg <= adx_w[30:0];
            f1_ady_reg <= ady_w[30:0];
            f1_rsum_reg <= rsum_w;
            f1_sx_reg <= dx[32];
            f1_sy_reg <= dy[32];
            f1_rej_reg <= (adx_w > {2'b00, rsum_w}) || (ady_w > {2'b00, rsum_w});

            f2_ax_reg <= f1_ax_reg;
            f2_ay_reg <= f1_ay_reg;
            f2_ar_reg <= f1_ar_reg;
            f2_adx_reg <= f1_adx_reg;
            f2_ady_reg <= f1_ady_reg;
            f2_rsum_reg <= f1_rsum_reg;
            f2_sx_reg <= f1_sx_reg;
            f2_sy_reg <= f1_sy_reg;
            f2_rej_reg <= f1_rej_reg;
            f2_sqx_reg <= 62'(f1_adx_reg) * 62'(f1_adx_reg);
            f2_sqy_reg <= 62'(f1_ady_reg) * 62'(f1_ady_reg);
            f2_rs2_reg <= 62'(f1_rsum_reg) * 62'(f1_rsum_reg);

            f3_job_reg <= job_next;
        end
    end

    assign job_valid = f3_v_reg;
    assign job = f3_job_reg;

endmodule

`default_nettype wire

@@ design/cc_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none

module cc_queue import cc_pkg::*; (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic in_valid,
    output logic      in_ready,
    input  job_t      in_job,
    output logic      out_valid,
    input  wire logic out_ready,
    output job_t      out_job
);

    localparam int PW = $clog2(Q_DEPTH);

    job_t          mem_reg [Q_DEPTH];
    logic [PW-1:0] wptr_reg, rptr_reg;
    logic [PW:0]   count_reg;
    logic          push, pop;

    assign in_ready = (count_reg != (PW+1)'(Q_DEPTH));
    assign out_valid = (count_reg != '0);
    assign push = in_valid && in_ready;
    assign pop = out_valid && out_ready;
    assign out_job = mem_reg[rptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wptr_reg] <= in_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            count_reg <= '0;
        end else begin
            if (push) begin
                wptr_reg <= wptr_reg + 1'b1;
            end
            if (pop) begin
                rptr_reg <= rptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

@@ design/cc_back.sv @@
`timescale 1ns / 1ps
`default_nettype none

module cc_back import cc_pkg::*; (
    input  wire logic   aclk,
    input  wire logic   aresetn,
    input  wire logic   job_valid,
    input  job_t        job,
    output logic        job_ready,
    output logic        m_valid,
    input  wire logic   m_ready,
    output logic        m_hit,
    output logic [30:0] m_depth,
    output logic signed [16:0] m_normal_x,
    output logic signed [16:0] m_normal_y,
    output logic signed [31:0] m_contact_x,
    output logic signed [31:0] m_contact_y
);

    typedef struct packed {
        logic [32:0] rem;
        logic [30:0] root;
        logic [61:0] d2s;
    } sq_t;

    function automatic sq_t sqrt_step(input sq_t cur);
        logic [34:0] r2;
        logic [34:0] t;
        sq_t o;
        r2 = {cur.rem, cur.d2s[61:60]};
        t = {2'b00, cur.root, 2'b01};
        if (r2 >= t) begin
            o.rem = 33'(r2 - t);
            o.root = {cur.root[29:0], 1'b1};
        end else begin
            o.rem = r2[32:0];
            o.root = {cur.root[29:0], 1'b0};
        end
        o.d2s = {cur.d2s[59:0], 2'b00};
        return o;
    endfunction

    function automatic logic [47:0] div_step(input logic [46:0] rem, input logic [30:0] dlen,
                                             input int sh);
        logic [46:0] dd;
        dd = 47'(dlen) << sh;
        if (rem >= dd) begin
            return {1'b1, rem - dd};
        end
        return {1'b0, rem};
    endfunction

    function automatic logic signed [31:0] move(input logic signed [31:0] c, input logic neg,
                                                input logic [45:0] p);
        logic [30:0]        o;
        logic signed [33:0] s;
        o = 31'((p + 46'd16384) >> 15);
        s = neg ? (34'(c) - $signed({3'b000, o})) : (34'(c) + $signed({3'b000, o}));
        if (s > 34'sh07FFFFFFF) begin
            return 32'sh7FFFFFFF;
        end else if (s < -34'sh080000000) begin
            return 32'sh80000000;
        end
        return s[31:0];
    endfunction

    logic be;

    sq_t  sq_c [SQ_N];
    logic sq_v_reg [SQ_N];
    sq_t  sq_reg [SQ_N];
    job_t sq_job_reg [SQ_N];

    logic        pr_v_reg;
    job_t        pr_job_reg;
    logic [30:0] pr_dist_reg, pr_depth_reg;
    logic [46:0] pr_nx_reg, pr_ny_reg;

    logic [47:0] dvx_c [DV_N];
    logic [47:0] dvy_c [DV_N];
    logic        dv_v_reg [DV_N];
    job_t        dv_job_reg [DV_N];
    logic [30:0] dv_dist_reg [DV_N];
    logic [30:0] dv_depth_reg [DV_N];
    logic [46:0] dv_rx_reg [DV_N];
    logic [46:0] dv_ry_reg [DV_N];
    logic [15:0] dv_qx_reg [DV_N];
    logic [15:0] dv_qy_reg [DV_N];

    logic        mu_v_reg;
    job_t        mu_job_reg;
    logic [30:0] mu_depth_reg;
    logic [15:0] mu_qx_reg, mu_qy_reg;
    logic [45:0] mu_px_reg, mu_py_reg;

    logic        m_valid_reg, m_hit_reg;
    logic [30:0] m_depth_reg;
    logic signed [16:0] m_nx_reg, m_ny_reg;
    logic signed [31:0] m_cx_reg, m_cy_reg;

    sq_t  sq_in;
    logic [30:0] dist_w;

    assign be = !m_valid_reg || m_ready;
    assign job_ready = be;

    always_comb begin
        sq_in.rem = '0;
        sq_in.root = '0;
        sq_in.d2s = job.d2;
        sq_c[0] = sqrt_step(sq_in);
        for (int k = 1; k < SQ_N; k++) begin
            sq_c[k] = sqrt_step(sq_reg[k-1]);
        end
        dist_w = sq_reg[SQ_N-1].root;
        dvx_c[0] = div_step(pr_nx_reg, pr_dist_reg, DV_N - 1);
        dvy_c[0] = div_step(pr_ny_reg, pr_dist_reg, DV_N - 1);
        for (int k = 1; k < DV_N; k++) begin
            dvx_c[k] = div_step(dv_rx_reg[k-1], dv_dist_reg[k-1], DV_N - 1 - k);
            dvy_c[k] = div_step(dv_ry_reg[k-1], dv_dist_reg[k-1], DV_N - 1 - k);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < SQ_N; k++) begin
                sq_v_reg[k] <= 1'b0;
            end
            for (int k = 0; k < DV_N; k++) begin
                dv_v_reg[k] <= 1'b0;
            end
            pr_v_reg <= 1'b0;
            mu_v_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else if (be) begin
            sq_v_reg[0] <= job_valid;
            for (int k = 1; k < SQ_N; k++) begin
                sq_v_reg[k] <= sq_v_reg[k-1];
            end
            pr_v_reg <= sq_v_reg[SQ_N-1];
            dv_v_reg[0] <= pr_v_reg;
            for (int k = 1; k < DV_N; k++) begin
                dv_v_reg[k] <= dv_v_reg[k-1];
            end
            mu_v_reg <= dv_v_reg[DV_N-1];
            m_valid_reg <= mu_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (be) begin
            for (int k = 0; k < SQ_N; k++) begin
                sq_reg[k] <= sq_c[k];
            end
            sq_job_reg[0] <= job;
            for (int k = 1; k < SQ_N; k++) begin
                sq_job_reg[k] <= sq_job_reg[k-1];
            end

            pr_job_reg <= sq_job_reg[SQ_N-1];
            pr_dist_reg <= dist_w;
            pr_depth_reg <= sq_job_reg[SQ_N-1].rsum - dist_w;
            pr_nx_reg <= {1'b0, sq_job_reg[SQ_N-1].adx, 15'd0} + 47'(dist_w >> 1);
            pr_ny_reg <= {1'b0, sq_job_reg[SQ_N-1].ady, 15'd0} + 47'(dist_w >> 1);

            dv_job_reg[0] <= pr_job_reg;
            dv_dist_reg[0] <= pr_dist_reg;
            dv_depth_reg[0] <= pr_depth_reg;
            dv_rx_reg[0] <= dvx_c[0][46:0];
            dv_ry_reg[0] <= dvy_c[0][46:0];
            dv_qx_reg[0] <= {15'd0, dvx_c[0][47]};
            dv_qy_reg[0] <= {15'd0, dvy_c[0][47]};
            for (int k = 1; k < DV_N; k++) begin
                dv_job_reg[k] <= dv_job_reg[k-1];
                dv_dist_reg[k] <= dv_dist_reg[k-1];
                dv_depth_reg[k] <= dv_depth_reg[k-1];
                dv_rx_reg[k] <= dvx_c[k][46:0];
                dv_ry_reg[k] <= dvy_c[k][46:0];
                dv_qx_reg[k] <= {dv_qx_reg[k-1][14:0], dvx_c[k][47]};
                dv_qy_reg[k] <= {dv_qy_reg[k-1][14:0], dvy_c[k][47]};
            end

            mu_job_reg <= dv_job_reg[DV_N-1];
            mu_depth_reg <= dv_depth_reg[DV_N-1];
            mu_qx_reg <= dv_qx_reg[DV_N-1];
            mu_qy_reg <= dv_qy_reg[DV_N-1];
            mu_px_reg <= 46'(dv_qx_reg[DV_N-1]) * 46'(dv_job_reg[DV_N-1].ar);
            mu_py_reg <= 46'(dv_qy_reg[DV_N-1]) * 46'(dv_job_reg[DV_N-1].ar);

            case (mu_job_reg.kind)
                KIND_HIT: begin
                    m_hit_reg <= 1'b1;
                    m_depth_reg <= mu_depth_reg;
                    m_nx_reg <= mu_job_reg.sx ? -$signed({1'b0, mu_qx_reg})
                                              : $signed({1'b0, mu_qx_reg});
                    m_ny_reg <= mu_job_reg.sy ? -$signed({1'b0, mu_qy_reg})
                                              : $signed({1'b0, mu_qy_reg});
                    m_cx_reg <= move(mu_job_reg.ax, mu_job_reg.sx, mu_px_reg);
                    m_cy_reg <= move(mu_job_reg.ay, mu_job_reg.sy, mu_py_reg);
                end
                KIND_COINCIDENT: begin
                    m_hit_reg <= 1'b1;
                    m_depth_reg <= {1'b0, mu_job_reg.ar};
                    m_nx_reg <= 17'sd32768;
                    m_ny_reg <= '0;
                    m_cx_reg <= mu_job_reg.ax;
                    m_cy_reg <= mu_job_reg.ay;
                end
                default: begin
                    m_hit_reg <= 1'b0;
                    m_depth_reg <= '0;
                    m_nx_reg <= '0;
                    m_ny_reg <= '0;
                    m_cx_reg <= '0;
                    m_cy_reg <= '0;
                end
            endcase
        end
    end

    assign m_valid = m_valid_reg;
    assign m_hit = m_hit_reg;
    assign m_depth = m_depth_reg;
    assign m_normal_x = m_nx_reg;
    assign m_normal_y = m_ny_reg;
    assign m_contact_x = m_cx_reg;
    assign m_contact_y = m_cy_reg;

endmodule

`default_nettype wire

@@ design/circle_circle_contact.sv @@
// Channel   Direction  Handshake            Payload
// s_        in         s_valid / s_ready    circle A and B centers, radii (Q16.16)
// m_        out        m_valid / m_ready    hit, depth, normal (Q1.15), contact point
//
// One circle pair is accepted per cycle and one result leaves per cycle when nothing stalls.
// The path has three front stages, the queue, and a back pipeline with 31 square
// root steps, division stages, a multiply and an output stage.
// Reset is synchronous and active low and empties every stage and the queue.
// A stalled result stalls the back pipeline; the front keeps accepting until the
// four-entry queue fills.
`timescale 1ns / 1ps
`default_nettype none

module circle_circle_contact import cc_pkg::*; (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic signed [31:0] s_a_center_x,
    input  wire logic signed [31:0] s_a_center_y,
    input  wire logic [29:0]        s_a_radius,
    input  wire logic signed [31:0] s_b_center_x,
    input  wire logic signed [31:0] s_b_center_y,
    input  wire logic [29:0]        s_b_radius,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic                    m_hit,
    output logic [30:0]             m_depth,
    output logic signed [16:0]      m_normal_x,
    output logic signed [16:0]      m_normal_y,
    output logic signed [31:0]      m_contact_x,
    output logic signed [31:0]      m_contact_y
);

    logic fq_valid, fq_ready, qb_valid, qb_ready;
    job_t fq_job, qb_job;

    cc_front u_front (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_a_center_x(s_a_center_x), .s_a_center_y(s_a_center_y),
        .s_a_radius(s_a_radius),
        .s_b_center_x(s_b_center_x), .s_b_center_y(s_b_center_y),
        .s_b_radius(s_b_radius),
        .job_valid(fq_valid), .job(fq_job), .job_ready(fq_ready)
    );

    cc_queue u_queue (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(fq_valid), .in_ready(fq_ready), .in_job(fq_job),
        .out_valid(qb_valid), .out_ready(qb_ready), .out_job(qb_job)
    );

    cc_back u_back (
        .aclk(aclk), .aresetn(aresetn),
        .job_valid(qb_valid), .job(qb_job), .job_ready(qb_ready),
        .m_valid(m_valid), .m_ready(m_ready), .m_hit(m_hit), .m_depth(m_depth),
        .m_normal_x(m_normal_x), .m_normal_y(m_normal_y),
        .m_contact_x(m_contact_x), .m_contact_y(m_contact_y)
    );

endmodule

`default_nettype wire

@@ design/cc_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none

module cc_checker (
    input wire logic               aclk,
    input wire logic               aresetn,
    input wire logic               m_valid,
    input wire logic               m_ready,
    input wire logic               m_hit,
    input wire logic [30:0]        m_depth,
    input wire logic signed [16:0] m_normal_x,
    input wire logic signed [16:0] m_normal_y,
    input wire logic signed [31:0] m_contact_x,
    input wire logic signed [31:0] m_contact_y
);

    a_reset_clears: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result dropped while stalled");

    a_hold_depth: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(m_depth) && $stable(m_contact_x))
        else $error("result changed while stalled");

    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_hit |-> m_depth == 31'd0 && m_normal_x == 17'sd0 &&
        m_normal_y == 17'sd0 && m_contact_x == 32'sd0 && m_contact_y == 32'sd0)
        else $error("miss with nonzero fields");

    a_normal_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_hit |-> m_normal_x <= 17'sd32768 && m_normal_x >= -17'sd32768 &&
        m_normal_y <= 17'sd32768 && m_normal_y >= -17'sd32768)
        else $error("normal out of range");

endmodule

bind circle_circle_contact cc_checker u_cc_checker (
    .aclk(aclk), .aresetn(aresetn), .m_valid(m_valid), .m_ready(m_ready),
    .m_hit(m_hit), .m_depth(m_depth), .m_normal_x(m_normal_x), .m_normal_y(m_normal_y),
    .m_contact_x(m_contact_x), .m_contact_y(m_contact_y)
);

`default_nettype wire

@@ dv/tb.sv @@
`timescale 1ns / 1ps

module tb;

    typedef struct {
        logic signed [31:0] ax;
        logic signed [31:0] ay;
        logic [29:0]        ar;
        logic signed [31:0] bx;
        logic signed [31:0] by;
        logic [29:0]        br;
    } pair_t;

    typedef struct {
        logic               hit;
        logic [30:0]        depth;
        logic signed [16:0] nx;
        logic signed [16:0] ny;
        logic signed [31:0] cx;
        logic signed [31:0] cy;
    } contact_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic signed [31:0] s_a_center_x = '0;
    logic signed [31:0] s_a_center_y = '0;
    logic [29:0] s_a_radius = '0;
    logic signed [31:0] s_b_center_x = '0;
    logic signed [31:0] s_b_center_y = '0;
    logic [29:0] s_b_radius = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic m_hit;
    logic [30:0] m_depth;
    logic signed [16:0] m_normal_x;
    logic signed [16:0] m_normal_y;
    logic signed [31:0] m_contact_x;
    logic signed [31:0] m_contact_y;
    logic s_ready_seen = 1'b0;

    circle_circle_contact dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_a_center_x(s_a_center_x), .s_a_center_y(s_a_center_y),
        .s_a_radius(s_a_radius),
        .s_b_center_x(s_b_center_x), .s_b_center_y(s_b_center_y),
        .s_b_radius(s_b_radius),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_hit(m_hit), .m_depth(m_depth),
        .m_normal_x(m_normal_x), .m_normal_y(m_normal_y),
        .m_contact_x(m_contact_x), .m_contact_y(m_contact_y)
    );

    pair_t    pending_pairs[$];
    contact_t expected_contacts[$];
    int  send_idle_pct = 0;
    int  recv_stall_pct = 0;
    int  hold_off_cycles = 0;
    bit  stimulus_done = 1'b0;
    int  error_count = 0;
    longint cycle_count = 0;

    initial begin
        forever #4 aclk = ~aclk;
    end

    function automatic longint unsigned int_sqrt(longint unsigned x);
        longint unsigned res;
        longint unsigned bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > x) bitv >>= 2;
        while (bitv != 0) begin
            if (x >= res + bitv) begin
                x -= res + bitv;
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    function automatic longint unit_component(longint d, longint unsigned dlen);
        longint unsigned m;
        longint unsigned q;
        m = (d < 0) ? longint'(-d) : longint'(d);
        q = (m * 64'd32768 + dlen / 2) / dlen;
        return (d < 0) ? -longint'(q) : longint'(q);
    endfunction

    function automatic logic signed [31:0] shift_along(longint c, longint n,
                                                        longint unsigned r);
        longint unsigned m;
        longint unsigned o;
        longint v;
        m = (n < 0) ? longint'(-n) : longint'(n);
        o = (m * r + 64'd16384) >> 15;
        v = (n < 0) ? c - longint'(o) : c + longint'(o);
        if (v > 64'sd2147483647) v = 64'sd2147483647;
        if (v < -64'sd2147483648) v = -64'sd2147483648;
        return v[31:0];
    endfunction

    function automatic contact_t predict_contact(pair_t p);
        contact_t res;
        longint dx;
        longint dy;
        longint unsigned adx;
        longint unsigned ady;
        longint unsigned rsum;
        longint unsigned d2;
        longint unsigned dlen;
        longint nx;
        longint ny;
        res = '{1'b0, '0, '0, '0, '0, '0};
        dx = longint'(p.bx) - longint'(p.ax);
        dy = longint'(p.by) - longint'(p.ay);
        adx = (dx < 0) ? -dx : dx;
        ady = (dy < 0) ? -dy : dy;
        rsum = longint'(p.ar) + longint'(p.br);
        if (adx > rsum || ady > rsum) return res;
        d2 = adx * adx + ady * ady;
        if (d2 > rsum * rsum) return res;
        res.hit = 1'b1;
        if (d2 == 0) begin
            res.depth = {1'b0, p.ar};
            res.nx = 17'sd32768;
            res.ny = '0;
            res.cx = p.ax;
            res.cy = p.ay;
        end else begin
            dlen = int_sqrt(d2);
            res.depth = 31'(rsum - dlen);
            nx = unit_component(dx, dlen);
            ny = unit_component(dy, dlen);
            res.nx = nx[16:0];
            res.ny = ny[16:0];
            res.cx = shift_along(p.ax, nx, p.ar);
            res.cy = shift_along(p.ay, ny, p.ar);
        end
        return res;
    endfunction

    function automatic logic signed [31:0] rand_coord();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return 32'sd2147483647 - $urandom_range(0, 255);
            2: return -32'sd2147483648 + $urandom_range(0, 255);
            default: return $signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000;
        endcase
    endfunction

    function automatic pair_t rand_pair();
        pair_t p;
        logic signed [31:0] off;
        p.ax = rand_coord();
        p.ay = rand_coord();
        p.ar = ($urandom_range(0, 3) == 0) ? 30'($urandom)
                                           : 30'($urandom_range(0, 32'h0030_0000));
        p.br = ($urandom_range(0, 3) == 0) ? 30'($urandom)
                                           : 30'($urandom_range(0, 32'h0030_0000));
        case ($urandom_range(0, 5))
            0: begin
                p.bx = rand_coord();
                p.by = rand_coord();
            end
            1: begin
                p.bx = p.ax;
                p.by = p.ay;
            end
            default: begin
                off = $signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000;
                p.bx = p.ax + off;
                off = $signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000;
                p.by = p.ay + off;
            end
        endcase
        return p;
    endfunction

    task automatic queue_pair(logic signed [31:0] ax, logic signed [31:0] ay, logic [29:0] ar,
                              logic signed [31:0] bx, logic signed [31:0] by,
                              logic [29:0] br);
        pair_t p;
        p = '{ax, ay, ar, bx, by, br};
        pending_pairs.push_back(p);
    endtask

    task automatic wait_drained();
        while (pending_pairs.size() != 0 || s_valid || expected_contacts.size() != 0)
            @(posedge aclk);
    endtask

    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready_seen) begin
            if (pending_pairs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                pair_t p;
                p = pending_pairs.pop_front();
                s_a_center_x <= p.ax;
                s_a_center_y <= p.ay;
                s_a_radius <= p.ar;
                s_b_center_x <= p.bx;
                s_b_center_y <= p.by;
                s_b_radius <= p.br;
                s_valid <= 1'b1;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    always @(posedge aclk) begin
        s_ready_seen <= aresetn && s_valid && s_ready;
        if (aresetn && s_valid && s_ready) begin
            pair_t p;
            p = '{s_a_center_x, s_a_center_y, s_a_radius,
                  s_b_center_x, s_b_center_y, s_b_radius};
            expected_contacts.push_back(predict_contact(p));
        end
    end

    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_off_cycles > 0) begin
            m_ready <= 1'b0;
            hold_off_cycles <= hold_off_cycles - 1;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_contacts.size() == 0) begin
                $display("%0t: result with none expected: hit=%0d depth=%0d", $time,
                         m_hit, m_depth);
                error_count <= error_count + 1;
            end else begin
                contact_t e;
                e = expected_contacts.pop_front();
                if (e.hit !== m_hit || e.depth !== m_depth || e.nx !== m_normal_x ||
                    e.ny !== m_normal_y || e.cx !== m_contact_x || e.cy !== m_contact_y) begin
                    $display("%0t: mismatch expected hit=%0d depth=%0d n=(%0d,%0d) c=(%0d,%0d)",
                             $time, e.hit, e.depth, e.nx, e.ny, e.cx, e.cy);
                    $display("%0t:          actual   hit=%0d depth=%0d n=(%0d,%0d) c=(%0d,%0d)",
                             $time, m_hit, m_depth, m_normal_x, m_normal_y,
                             m_contact_x, m_contact_y);
                    error_count <= error_count + 1;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 400000) begin
            $display("tb: errors");
            $finish;
        end
    end

    initial begin
        int n;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        queue_pair(0, 0, 30'h0, 0, 0, 30'h0);
        queue_pair(0, 0, 30'h3FFF_FFFF, 0, 0, 30'h3FFF_FFFF);
        queue_pair(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 30'h3FFF_FFFF,
                   -32'sh8000_0000, -32'sh8000_0000, 30'h3FFF_FFFF);
        queue_pair(-32'sh8000_0000, 0, 30'h3FFF_FFFF, 32'sh7FFF_FFFF, 0, 30'h3FFF_FFFF);
        queue_pair(0, 0, 30'h0001_0000, 32'sh0002_0000, 0, 30'h0001_0000);
        queue_pair(0, 0, 30'h0001_0000, 32'sh0002_0001, 0, 30'h0001_0000);
        queue_pair(0, 0, 30'h0001_0000, 0, -32'sh0001_8000, 30'h0001_0000);
        queue_pair(32'sh0001_0000, 32'sh0001_0000, 30'h0002_0000,
                   -32'sh0001_0000, -32'sh0001_0000, 30'h0002_0000);
        queue_pair(32'sh7FFF_0000, 0, 30'h3FFF_FFFF, 32'sh7FFF_FFFF, 0, 30'h0);
        queue_pair(-32'sh7FFF_0000, -32'sh7FFF_0000, 30'h3FFF_FFFF,
                   -32'sh8000_0000, -32'sh8000_0000, 30'h0);
        queue_pair(32'sh1234_5678, -32'sh1234_5678, 30'h0000_5000,
                   32'sh1234_5678, -32'sh1234_5678, 30'h0);
        queue_pair(0, 0, 30'h0, 32'sh0000_0003, 32'sh0000_0004, 30'h0000_0005);
        queue_pair(0, 0, 30'h0000_0005, 32'sh0000_0003, 32'sh0000_0004, 30'h0);
        queue_pair(-32'sh8000_0000, 32'sh7FFF_FFFF, 30'h1555_5555,
                   -32'sh8000_0000, 32'sh7FFF_FFFF, 30'h2AAA_AAAA);
        queue_pair(32'sh5555_5555, 32'shAAAA_AAAA, 30'h2AAA_AAAA,
                   32'sh5555_5556, 32'shAAAA_AAA9, 30'h1555_5555);
        wait_drained();

        for (int phase = 0; phase < 5; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 65; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 65; end
                3: begin send_idle_pct = 16; recv_stall_pct = 16; end
                default: begin send_idle_pct = 0; recv_stall_pct = 0; end
            endcase
            n = (phase == 4) ? 200 : 350;
            for (int i = 0; i < n; i++) pending_pairs.push_back(rand_pair());
            if (phase == 4) hold_off_cycles = 300;
            wait_drained();
        end

        repeat (80) @(posedge aclk);
        if (error_count == 0 && expected_contacts.size() == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end

endmodule
